/* rtl/core/lav_pkg.sv */
// ----------------------------------------------------------------------------
// lav_pkg: shared types, constants and rounding helpers
// Fixed-point formats, status codes and the matrix record handed to the
// output stage of the look-at matrix builder.
// ----------------------------------------------------------------------------
package lav_pkg;

    // status codes
    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_EYE = 2'd1;
    localparam logic [1:0] STAT_PAR = 2'd2;

    // last column index
    localparam logic [1:0] COL_LAST = 2'd3;

    // fixed-point constants
    localparam logic signed [31:0] Q16_ONE = 32'sh0001_0000;
    localparam int unsigned UNIT_FRAC = 30;   // Q2.30 fraction bits
    localparam int unsigned ROT_SH    = 14;   // Q2.30 -> Q16.16

    // normalizer geometry
    localparam int D_W       = 33;  // centre - eye
    localparam int SR_W      = 64;  // f x up
    localparam int SCALE_MSB = 29;  // largest scaled magnitude lands in [2^29, 2^30)
    localparam int SC_W      = 30;
    localparam int SQ_W      = 62;  // sum of squares
    localparam int SQ_N      = 31;  // root bits
    localparam int LEN_W     = 31;
    localparam int NUM_W     = 61;  // dividend
    localparam int QT_W      = 31;  // quotient bits

    // sideband carried through the first normalizer
    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][31:0] up;
    } lav_sbf_t;

    // sideband carried through the second normalizer
    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][31:0] f;
        logic             ok_f;
    } lav_sbs_t;

    // finished matrix, rot[row][col]
    typedef struct packed {
        logic [1:0]            status;
        logic [2:0][2:0][31:0] rot;
        logic [2:0][31:0]      trn;
    } lav_mat_t;

    // shift right by n with rounding half away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned n);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? (~v + 64'd1) : v;
        r = (m + (64'd1 << (n - 1))) >> n;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    // clamp to the Q16.16 range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

/* rtl/core/lav_norm.sv */
// ----------------------------------------------------------------------------
// lav_norm: pipelined vector normalizer
// Scales three magnitudes so the largest lies in [2^29, 2^30), takes the
// integer root of the sum of squares one bit per stage, then divides each
// component one quotient bit per stage. Output is Q2.30 with sign restored.
// ----------------------------------------------------------------------------
module lav_norm
    import lav_pkg::*;
#(
    parameter int W    = D_W,
    parameter int SB_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [W-1:0] in_vec [3],
    input  logic [SB_W-1:0]     in_sb,
    output logic                out_valid,
    output logic signed [31:0]  out_unit [3],
    output logic                out_ok,
    output logic [SB_W-1:0]     out_sb
);
    localparam int PW   = $clog2(W);
    localparam int NSTG = 5 + SQ_N + 1 + QT_W;

    // valid bits travel as one shift line
    logic [NSTG-1:0] v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NSTG-2:0], in_valid};
        end
    end

    // stage 0: magnitudes and signs
    logic [W-1:0]    p0_mag_reg [3];
    logic [2:0]      p0_sgn_reg;
    logic [SB_W-1:0] p0_sb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p0_mag_reg[i] <= in_vec[i][W-1] ? W'(-in_vec[i]) : W'(in_vec[i]);
                p0_sgn_reg[i] <= in_vec[i][W-1];
            end
            p0_sb_reg <= in_sb;
        end
    end

    // stage 1: leading one of the OR of all magnitudes
    logic [W-1:0]  or_mag;
    logic [PW-1:0] msb_pos;

    always_comb begin
        or_mag  = p0_mag_reg[0] | p0_mag_reg[1] | p0_mag_reg[2];
        msb_pos = '0;
        for (int b = 0; b < W; b++) begin
            if (or_mag[b]) msb_pos = PW'(b);
        end
    end

    logic [W-1:0]    p1_mag_reg [3];
    logic [2:0]      p1_sgn_reg;
    logic            p1_ok_reg;
    logic [PW-1:0]   p1_pos_reg;
    logic [SB_W-1:0] p1_sb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_mag_reg <= p0_mag_reg;
            p1_sgn_reg <= p0_sgn_reg;
            p1_ok_reg  <= |or_mag;
            p1_pos_reg <= msb_pos;
            p1_sb_reg  <= p0_sb_reg;
        end
    end

    // stage 2: common scaling shift
    logic [W-1:0] sh_mag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (p1_pos_reg >= PW'(SCALE_MSB)) begin
                sh_mag[i] = p1_mag_reg[i] >> (p1_pos_reg - PW'(SCALE_MSB));
            end else begin
                sh_mag[i] = p1_mag_reg[i] << (PW'(SCALE_MSB) - p1_pos_reg);
            end
        end
    end

    logic [SC_W-1:0] p2_sc_reg [3];
    logic [2:0]      p2_sgn_reg;
    logic            p2_ok_reg;
    logic [SB_W-1:0] p2_sb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) p2_sc_reg[i] <= sh_mag[i][SC_W-1:0];
            p2_sgn_reg <= p1_sgn_reg;
            p2_ok_reg  <= p1_ok_reg;
            p2_sb_reg  <= p1_sb_reg;
        end
    end

    // stage 3: squares
    logic [2*SC_W-1:0] p3_sq_reg [3];
    logic [SC_W-1:0]   p3_sc_reg [3];
    logic [2:0]        p3_sgn_reg;
    logic              p3_ok_reg;
    logic [SB_W-1:0]   p3_sb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) p3_sq_reg[i] <= p2_sc_reg[i] * p2_sc_reg[i];
            p3_sc_reg  <= p2_sc_reg;
            p3_sgn_reg <= p2_sgn_reg;
            p3_ok_reg  <= p2_ok_reg;
            p3_sb_reg  <= p2_sb_reg;
        end
    end

    // stage 4: sum of squares feeds the root pipeline
    logic [SQ_W-1:0] sq_x_reg   [SQ_N+1];
    logic [SQ_W-1:0] sq_r_reg   [SQ_N+1];
    logic [SC_W-1:0] sq_sc_reg  [SQ_N+1][3];
    logic [2:0]      sq_sgn_reg [SQ_N+1];
    logic            sq_ok_reg  [SQ_N+1];
    logic [SB_W-1:0] sq_sb_reg  [SQ_N+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_x_reg[0]   <= SQ_W'(p3_sq_reg[0]) + SQ_W'(p3_sq_reg[1])
                             + SQ_W'(p3_sq_reg[2]);
            sq_r_reg[0]   <= '0;
            sq_sc_reg[0]  <= p3_sc_reg;
            sq_sgn_reg[0] <= p3_sgn_reg;
            sq_ok_reg[0]  <= p3_ok_reg;
            sq_sb_reg[0]  <= p3_sb_reg;
        end
    end

    // integer root, one result bit per stage
    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_N - 1 - k));
        logic [SQ_W-1:0] trial;

        assign trial = sq_r_reg[k] + BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (sq_x_reg[k] >= trial) begin
                    sq_x_reg[k+1] <= sq_x_reg[k] - trial;
                    sq_r_reg[k+1] <= (sq_r_reg[k] >> 1) + BIT;
                end else begin
                    sq_x_reg[k+1] <= sq_x_reg[k];
                    sq_r_reg[k+1] <= sq_r_reg[k] >> 1;
                end
                sq_sc_reg[k+1]  <= sq_sc_reg[k];
                sq_sgn_reg[k+1] <= sq_sgn_reg[k];
                sq_ok_reg[k+1]  <= sq_ok_reg[k];
                sq_sb_reg[k+1]  <= sq_sb_reg[k];
            end
        end
    end

    // dividend setup: m * 2^30 + len / 2
    logic [LEN_W-1:0] root_len;
    assign root_len = sq_r_reg[SQ_N][LEN_W-1:0];

    logic [NUM_W-1:0] dv_rem_reg [QT_W+1][3];
    logic [QT_W-1:0]  dv_q_reg   [QT_W+1][3];
    logic [LEN_W-1:0] dv_len_reg [QT_W+1];
    logic [2:0]       dv_sgn_reg [QT_W+1];
    logic             dv_ok_reg  [QT_W+1];
    logic [SB_W-1:0]  dv_sb_reg  [QT_W+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dv_rem_reg[0][i] <= {1'b0, sq_sc_reg[SQ_N][i], UNIT_FRAC'(0)}
                                    + NUM_W'(root_len >> 1);
                dv_q_reg[0][i]   <= '0;
            end
            dv_len_reg[0] <= root_len;
            dv_sgn_reg[0] <= sq_sgn_reg[SQ_N];
            dv_ok_reg[0]  <= sq_ok_reg[SQ_N];
            dv_sb_reg[0]  <= sq_sb_reg[SQ_N];
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < QT_W; j++) begin : g_div
        localparam int QB = QT_W - 1 - j;
        logic [NUM_W-1:0] dvs;

        assign dvs = NUM_W'(dv_len_reg[j]) << QB;

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (dv_rem_reg[j][i] >= dvs) begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i] - dvs;
                        dv_q_reg[j+1][i]   <= dv_q_reg[j][i] | (QT_W'(1) << QB);
                    end else begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i];
                        dv_q_reg[j+1][i]   <= dv_q_reg[j][i];
                    end
                end
                dv_len_reg[j+1] <= dv_len_reg[j];
                dv_sgn_reg[j+1] <= dv_sgn_reg[j];
                dv_ok_reg[j+1]  <= dv_ok_reg[j];
                dv_sb_reg[j+1]  <= dv_sb_reg[j];
            end
        end
    end

    // restore signs
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            out_unit[i] = dv_sgn_reg[QT_W][i] ? -$signed({1'b0, dv_q_reg[QT_W][i]})
                                              : $signed({1'b0, dv_q_reg[QT_W][i]});
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_ok    = dv_ok_reg[QT_W];
    assign out_sb    = dv_sb_reg[QT_W];

endmodule

/* rtl/core/lav_out.sv */
// ----------------------------------------------------------------------------
// lav_out: column serializer
// Holds one finished matrix and sends it one column per accepted beat, or a
// single status beat for a degenerate view.
// ----------------------------------------------------------------------------
module lav_out
    import lav_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ld_valid,
    input  lav_mat_t           ld_mat,
    output logic               can_load,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_column,
    output logic signed [31:0] m_elem_0,
    output logic signed [31:0] m_elem_1,
    output logic signed [31:0] m_elem_2,
    output logic signed [31:0] m_elem_3,
    output logic [1:0]         m_status,
    output logic               m_last
);
    logic       hold_v_reg;
    logic [1:0] col_reg;
    lav_mat_t   mat_reg;
    logic       last_beat;

    assign last_beat = (mat_reg.status != STAT_OK) || (col_reg == COL_LAST);
    assign can_load  = !hold_v_reg || (m_ready && last_beat);

    // hold register and column counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg <= 1'b0;
            col_reg    <= '0;
        end else if (can_load) begin
            hold_v_reg <= ld_valid;
            col_reg    <= '0;
        end else if (m_ready) begin
            col_reg <= col_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && ld_valid) mat_reg <= ld_mat;
    end

    // column select
    always_comb begin
        m_column = '0;
        m_elem_0 = '0;
        m_elem_1 = '0;
        m_elem_2 = '0;
        m_elem_3 = '0;
        if (mat_reg.status == STAT_OK) begin
            m_column = col_reg;
            case (col_reg)
                COL_LAST: begin
                    m_elem_0 = mat_reg.trn[0];
                    m_elem_1 = mat_reg.trn[1];
                    m_elem_2 = mat_reg.trn[2];
                    m_elem_3 = Q16_ONE;
                end
                default: begin
                    m_elem_0 = mat_reg.rot[0][col_reg];
                    m_elem_1 = mat_reg.rot[1][col_reg];
                    m_elem_2 = mat_reg.rot[2][col_reg];
                end
            endcase
        end
    end

    assign m_valid  = hold_v_reg;
    assign m_status = mat_reg.status;
    assign m_last   = last_beat;

endmodule

/* rtl/core/look_at_view_matrix.sv */
// Throughput: the result port sends one column per cycle while m_ready is high,
// which sets the rate for a valid matrix; one per cycle for a degenerate view.
// The 68-stage normalizers (bit-serial root and divide stages) set latency.
// Reset: synchronous active-low aresetn clears all valid bits; data needs none.
// ----------------------------------------------------------------------------
// look_at_view_matrix: fixed-point look-at view matrix builder
// Normalizes the view direction and side vector, forms the up vector and the
// translation, and streams the column-major matrix out one column at a time.
// ----------------------------------------------------------------------------
module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_eye_x,
    input  logic signed [31:0] s_eye_y,
    input  logic signed [31:0] s_eye_z,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_target_z,
    input  logic signed [31:0] s_up_x,
    input  logic signed [31:0] s_up_y,
    input  logic signed [31:0] s_up_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_column,
    output logic signed [31:0] m_elem_0,
    output logic signed [31:0] m_elem_1,
    output logic signed [31:0] m_elem_2,
    output logic signed [31:0] m_elem_3,
    output logic [1:0]         m_status,
    output logic               m_last
);
    logic en;
    logic can_load;

    // valid bits of the top-level stages
    logic t0_v_reg, t1_v_reg, t2_v_reg, t3_v_reg;
    logic t4_v_reg, t5_v_reg, t6_v_reg, t7_v_reg;
    logic nf_valid, ns_valid;

    // whole pipeline advances unless a finished matrix is blocked
    assign en      = can_load || !t7_v_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_v_reg <= 1'b0;
            t1_v_reg <= 1'b0;
            t2_v_reg <= 1'b0;
            t3_v_reg <= 1'b0;
            t4_v_reg <= 1'b0;
            t5_v_reg <= 1'b0;
            t6_v_reg <= 1'b0;
            t7_v_reg <= 1'b0;
        end else if (en) begin
            t0_v_reg <= s_valid;
            t1_v_reg <= nf_valid;
            t2_v_reg <= t1_v_reg;
            t3_v_reg <= ns_valid;
            t4_v_reg <= t3_v_reg;
            t5_v_reg <= t4_v_reg;
            t6_v_reg <= t5_v_reg;
            t7_v_reg <= t6_v_reg;
        end
    end

    // view direction d = centre - eye
    logic signed [D_W-1:0] t0_d_reg [3];
    lav_sbf_t              t0_sbf_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t0_d_reg[0]       <= D_W'(s_target_x) - D_W'(s_eye_x);
            t0_d_reg[1]       <= D_W'(s_target_y) - D_W'(s_eye_y);
            t0_d_reg[2]       <= D_W'(s_target_z) - D_W'(s_eye_z);
            t0_sbf_reg.eye[0] <= s_eye_x;
            t0_sbf_reg.eye[1] <= s_eye_y;
            t0_sbf_reg.eye[2] <= s_eye_z;
            t0_sbf_reg.up[0]  <= s_up_x;
            t0_sbf_reg.up[1]  <= s_up_y;
            t0_sbf_reg.up[2]  <= s_up_z;
        end
    end

    logic signed [31:0]     nf_unit [3];
    logic                   nf_ok;
    logic [$bits(lav_sbf_t)-1:0] nf_sb;
    lav_sbf_t               nf_sbf;

    lav_norm #(
        .W    (D_W),
        .SB_W ($bits(lav_sbf_t))
    ) u_norm_f (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (t0_v_reg),
        .in_vec    (t0_d_reg),
        .in_sb     (t0_sbf_reg),
        .out_valid (nf_valid),
        .out_unit  (nf_unit),
        .out_ok    (nf_ok),
        .out_sb    (nf_sb)
    );

    assign nf_sbf = nf_sb;

    // side vector products f x up
    logic signed [63:0] t1_p_reg [6];
    lav_sbs_t           t1_sbs_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_p_reg[0] <= nf_unit[1] * $signed(nf_sbf.up[2]);
            t1_p_reg[1] <= nf_unit[2] * $signed(nf_sbf.up[1]);
            t1_p_reg[2] <= nf_unit[2] * $signed(nf_sbf.up[0]);
            t1_p_reg[3] <= nf_unit[0] * $signed(nf_sbf.up[2]);
            t1_p_reg[4] <= nf_unit[0] * $signed(nf_sbf.up[1]);
            t1_p_reg[5] <= nf_unit[1] * $signed(nf_sbf.up[0]);
            t1_sbs_reg.eye  <= nf_sbf.eye;
            for (int i = 0; i < 3; i++) t1_sbs_reg.f[i] <= nf_unit[i];
            t1_sbs_reg.ok_f <= nf_ok;
        end
    end

    logic signed [SR_W-1:0] t2_sr_reg [3];
    lav_sbs_t               t2_sbs_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t2_sr_reg[0] <= t1_p_reg[0] - t1_p_reg[1];
            t2_sr_reg[1] <= t1_p_reg[2] - t1_p_reg[3];
            t2_sr_reg[2] <= t1_p_reg[4] - t1_p_reg[5];
            t2_sbs_reg   <= t1_sbs_reg;
        end
    end

    logic signed [31:0]          ns_unit [3];
    logic                        ns_ok;
    logic [$bits(lav_sbs_t)-1:0] ns_sb;
    lav_sbs_t                    ns_sbs;

    lav_norm #(
        .W    (SR_W),
        .SB_W ($bits(lav_sbs_t))
    ) u_norm_s (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (t2_v_reg),
        .in_vec    (t2_sr_reg),
        .in_sb     (t2_sbs_reg),
        .out_valid (ns_valid),
        .out_unit  (ns_unit),
        .out_ok    (ns_ok),
        .out_sb    (ns_sb)
    );

    assign ns_sbs = ns_sb;

    // products for u = s x f and the s.eye, f.eye dot products
    logic signed [63:0] t3_sf_reg [6];
    logic signed [63:0] t3_se_reg [3];
    logic signed [63:0] t3_fe_reg [3];
    logic signed [31:0] t3_s_reg  [3];
    logic signed [31:0] t3_f_reg  [3];
    logic [2:0][31:0]   t3_eye_reg;
    logic               t3_okf_reg, t3_oks_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t3_sf_reg[0] <= ns_unit[1] * $signed(ns_sbs.f[2]);
            t3_sf_reg[1] <= ns_unit[2] * $signed(ns_sbs.f[1]);
            t3_sf_reg[2] <= ns_unit[2] * $signed(ns_sbs.f[0]);
            t3_sf_reg[3] <= ns_unit[0] * $signed(ns_sbs.f[2]);
            t3_sf_reg[4] <= ns_unit[0] * $signed(ns_sbs.f[1]);
            t3_sf_reg[5] <= ns_unit[1] * $signed(ns_sbs.f[0]);
            for (int i = 0; i < 3; i++) begin
                t3_se_reg[i] <= ns_unit[i] * $signed(ns_sbs.eye[i]);
                t3_fe_reg[i] <= $signed(ns_sbs.f[i]) * $signed(ns_sbs.eye[i]);
                t3_s_reg[i]  <= ns_unit[i];
                t3_f_reg[i]  <= $signed(ns_sbs.f[i]);
            end
            t3_eye_reg <= ns_sbs.eye;
            t3_okf_reg <= ns_sbs.ok_f;
            t3_oks_reg <= ns_ok;
        end
    end

    // cross differences and dot sums
    logic signed [63:0] t4_ur_reg [3];
    logic signed [63:0] t4_ds_reg, t4_df_reg;
    logic signed [31:0] t4_s_reg  [3];
    logic signed [31:0] t4_f_reg  [3];
    logic [2:0][31:0]   t4_eye_reg;
    logic               t4_okf_reg, t4_oks_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t4_ur_reg[0] <= t3_sf_reg[0] - t3_sf_reg[1];
            t4_ur_reg[1] <= t3_sf_reg[2] - t3_sf_reg[3];
            t4_ur_reg[2] <= t3_sf_reg[4] - t3_sf_reg[5];
            t4_ds_reg    <= t3_se_reg[0] + t3_se_reg[1] + t3_se_reg[2];
            t4_df_reg    <= t3_fe_reg[0] + t3_fe_reg[1] + t3_fe_reg[2];
            t4_s_reg     <= t3_s_reg;
            t4_f_reg     <= t3_f_reg;
            t4_eye_reg   <= t3_eye_reg;
            t4_okf_reg   <= t3_okf_reg;
            t4_oks_reg   <= t3_oks_reg;
        end
    end

    // round u to Q2.30, round translation x and z
    logic signed [32:0] t5_u_reg [3];
    logic signed [63:0] t5_ts_reg, t5_tf_reg;
    logic signed [31:0] t5_s_reg [3];
    logic signed [31:0] t5_f_reg [3];
    logic [2:0][31:0]   t5_eye_reg;
    logic               t5_okf_reg, t5_oks_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                t5_u_reg[i] <= 33'(rnd_shift(t4_ur_reg[i], UNIT_FRAC));
            end
            t5_ts_reg  <= -rnd_shift(t4_ds_reg, UNIT_FRAC);
            t5_tf_reg  <= rnd_shift(t4_df_reg, UNIT_FRAC);
            t5_s_reg   <= t4_s_reg;
            t5_f_reg   <= t4_f_reg;
            t5_eye_reg <= t4_eye_reg;
            t5_okf_reg <= t4_okf_reg;
            t5_oks_reg <= t4_oks_reg;
        end
    end

    // u.eye products
    logic signed [63:0] t6_ue_reg [3];
    logic signed [63:0] t6_ts_reg, t6_tf_reg;
    logic signed [31:0] t6_s_reg [3];
    logic signed [31:0] t6_f_reg [3];
    logic signed [32:0] t6_u_reg [3];
    logic               t6_okf_reg, t6_oks_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                t6_ue_reg[i] <= t5_u_reg[i] * $signed(t5_eye_reg[i]);
            end
            t6_ts_reg  <= t5_ts_reg;
            t6_tf_reg  <= t5_tf_reg;
            t6_s_reg   <= t5_s_reg;
            t6_f_reg   <= t5_f_reg;
            t6_u_reg   <= t5_u_reg;
            t6_okf_reg <= t5_okf_reg;
            t6_oks_reg <= t5_oks_reg;
        end
    end

    // u.eye sum
    logic signed [63:0] t7_du_reg;
    logic signed [63:0] t7_ts_reg, t7_tf_reg;
    logic signed [31:0] t7_s_reg [3];
    logic signed [31:0] t7_f_reg [3];
    logic signed [32:0] t7_u_reg [3];
    logic               t7_okf_reg, t7_oks_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t7_du_reg  <= t6_ue_reg[0] + t6_ue_reg[1] + t6_ue_reg[2];
            t7_ts_reg  <= t6_ts_reg;
            t7_tf_reg  <= t6_tf_reg;
            t7_s_reg   <= t6_s_reg;
            t7_f_reg   <= t6_f_reg;
            t7_u_reg   <= t6_u_reg;
            t7_okf_reg <= t6_okf_reg;
            t7_oks_reg <= t6_oks_reg;
        end
    end

    // final rounding to Q16.16 and saturation
    lav_mat_t mat;

    always_comb begin
        if (!t7_okf_reg) begin
            mat.status = STAT_EYE;
        end else if (!t7_oks_reg) begin
            mat.status = STAT_PAR;
        end else begin
            mat.status = STAT_OK;
        end
        for (int i = 0; i < 3; i++) begin
            mat.rot[0][i] = 32'(rnd_shift(64'(t7_s_reg[i]), ROT_SH));
            mat.rot[1][i] = 32'(rnd_shift(64'(t7_u_reg[i]), ROT_SH));
            mat.rot[2][i] = 32'(-rnd_shift(64'(t7_f_reg[i]), ROT_SH));
        end
        mat.trn[0] = sat32(t7_ts_reg);
        mat.trn[1] = sat32(-rnd_shift(t7_du_reg, UNIT_FRAC));
        mat.trn[2] = sat32(t7_tf_reg);
    end

    lav_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld_valid (t7_v_reg),
        .ld_mat   (mat),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_column (m_column),
        .m_elem_0 (m_elem_0),
        .m_elem_1 (m_elem_1),
        .m_elem_2 (m_elem_2),
        .m_elem_3 (m_elem_3),
        .m_status (m_status),
        .m_last   (m_last)
    );

endmodule

/* rtl/core/lav_checker.sv */
// ----------------------------------------------------------------------------
// lav_checker: result port checks
// Watches the result channel for column order, last flag and status rules.
// ----------------------------------------------------------------------------
module lav_checker
    import lav_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_column,
    input logic signed [31:0] m_elem_3,
    input logic [1:0]         m_status,
    input logic               m_last
);
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_column) && $stable(m_status))
        else $error("result changed while stalled");

    // degenerate view is a single beat
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_last && m_column == 2'd0)
        else $error("degenerate result not single");

    // last only on the final column
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_OK |-> m_last == (m_column == COL_LAST))
        else $error("last flag out of place");

    // columns follow in order without gaps
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=>
            m_valid && m_column == $past(m_column) + 2'd1 && m_status == STAT_OK)
        else $error("column sequence broken");

    // homogeneous one in the translation column
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_OK && m_column == COL_LAST |-> m_elem_3 == Q16_ONE)
        else $error("bad row 3 of last column");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (.*);
